// File: rtl/eight_bit_alu_with_flags_assert.svh
// Assertion macros used by the checker file of the ALU.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_ASSERT_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_ASSERT_SVH

// Checked at every clock edge outside reset.
`define ALU8F_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ALU8F_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/alu8f_pkg.sv
package alu8f_pkg;

   localparam int unsigned OpWidth   = 4;
   localparam int unsigned DataWidth = 16;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned IdxWidth  = 3;
   localparam int unsigned FlagWidth = 4;

   typedef logic [OpWidth-1:0]   op_type;
   typedef logic [DataWidth-1:0] word_type;
   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [IdxWidth-1:0]  idx_type;
   typedef logic [FlagWidth-1:0] flags_type;

   localparam op_type OP_ADD   = 4'd0;
   localparam op_type OP_ADC   = 4'd1;
   localparam op_type OP_SUB   = 4'd2;
   localparam op_type OP_SBC   = 4'd3;
   localparam op_type OP_AND   = 4'd4;
   localparam op_type OP_XOR   = 4'd5;
   localparam op_type OP_OR    = 4'd6;
   localparam op_type OP_CP    = 4'd7;
   localparam op_type OP_INC   = 4'd8;
   localparam op_type OP_DEC   = 4'd9;
   localparam op_type OP_ADD16 = 4'd10;
   localparam op_type OP_BIT   = 4'd11;
   localparam op_type OP_RES   = 4'd12;
   localparam op_type OP_SET   = 4'd13;

   // Positions in the flag register.
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   // One operand beat held in the input register.
   typedef struct packed {
      op_type   op;
      word_type first_operand;
      word_type second_operand;
      idx_type  bit_index;
   } req_type;

endpackage

// File: rtl/eight_bit_alu_with_flags.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  op, first_operand, second_operand, bit_index
// rsp_      out        rsp_valid / rsp_stall  result, zero_out, subtract_out,
//                                             half_carry_out, carry_out
// One beat is taken per cycle while req_stall is low; a request beat passes through
// the input register and then the result register before its result is on the outputs.
// The input register feeds the ALU, whose output and flags are captured in the
// result register; the flag register is written as a beat moves into it.
// Synchronous reset clears the valid bits and the flags.
// With rsp_stall high on a held result, one more beat is taken into the input register;
// then req_stall rises until the result is taken.
module eight_bit_alu_with_flags (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  alu8f_pkg::op_type    req_op,
   input  alu8f_pkg::word_type  req_first_operand,
   input  alu8f_pkg::word_type  req_second_operand,
   input  alu8f_pkg::idx_type   req_bit_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output alu8f_pkg::word_type  rsp_result,
   output logic                 rsp_zero_out,
   output logic                 rsp_subtract_out,
   output logic                 rsp_half_carry_out,
   output logic                 rsp_carry_out
);

   logic                 in_valid_ff;
   alu8f_pkg::req_type   in_data_ff;
   logic                 out_valid_ff;
   alu8f_pkg::word_type  out_result_ff;
   alu8f_pkg::flags_type flags_ff;
   alu8f_pkg::flags_type flags_in;
   alu8f_pkg::word_type  result_in;

   logic out_open;
   logic in_move;
   logic req_take;

   alu8f_pkg::byte_type a;
   alu8f_pkg::byte_type b;
   logic                cin;
   logic [8:0]          sum9;
   logic [4:0]          sum_nib;
   logic [8:0]          diff9;
   logic [4:0]          diff_nib;
   alu8f_pkg::byte_type inc8;
   alu8f_pkg::byte_type dec8;
   logic [16:0]         sum17;
   logic [12:0]         sum13;
   alu8f_pkg::byte_type bit_mask;
   alu8f_pkg::byte_type byte_r;

   assign out_open  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign req_take  = req_valid && !req_stall;

   assign a = in_data_ff.first_operand[7:0];
   assign b = in_data_ff.second_operand[7:0];

   always_comb begin
      cin = 1'b0;
      if (in_data_ff.op == alu8f_pkg::OP_ADC || in_data_ff.op == alu8f_pkg::OP_SBC) begin
         cin = flags_ff[alu8f_pkg::FLAG_C];
      end
   end

   assign sum9     = {1'b0, a} + {1'b0, b} + {8'd0, cin};
   assign sum_nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
   // Bit 8 and bit 4 of the differences are the borrows.
   assign diff9    = {1'b0, a} - {1'b0, b} - {8'd0, cin};
   assign diff_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
   assign inc8     = b + 8'd1;
   assign dec8     = b - 8'd1;
   assign sum17    = {1'b0, in_data_ff.first_operand} + {1'b0, in_data_ff.second_operand};
   assign sum13    = {1'b0, in_data_ff.first_operand[11:0]}
                   + {1'b0, in_data_ff.second_operand[11:0]};
   assign bit_mask = 8'd1 << in_data_ff.bit_index;

   always_comb begin
      flags_in  = flags_ff;
      byte_r    = 8'd0;
      result_in = '0;
      case (in_data_ff.op)
         alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
            byte_r   = sum9[7:0];
            flags_in = {byte_r == 8'd0, 1'b0, sum_nib[4], sum9[8]};
         end
         alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC, alu8f_pkg::OP_CP: begin
            byte_r   = diff9[7:0];
            flags_in = {byte_r == 8'd0, 1'b1, diff_nib[4], diff9[8]};
            if (in_data_ff.op == alu8f_pkg::OP_CP) begin
               byte_r = a;
            end
         end
         alu8f_pkg::OP_AND: begin
            byte_r   = a & b;
            flags_in = {byte_r == 8'd0, 1'b0, 1'b1, 1'b0};
         end
         alu8f_pkg::OP_XOR: begin
            byte_r   = a ^ b;
            flags_in = {byte_r == 8'd0, 3'b000};
         end
         alu8f_pkg::OP_OR: begin
            byte_r   = a | b;
            flags_in = {byte_r == 8'd0, 3'b000};
         end
         alu8f_pkg::OP_INC: begin
            byte_r   = inc8;
            flags_in = {inc8 == 8'd0, 1'b0, b[3:0] == 4'hF, flags_ff[alu8f_pkg::FLAG_C]};
         end
         alu8f_pkg::OP_DEC: begin
            byte_r   = dec8;
            flags_in = {dec8 == 8'd0, 1'b1, b[3:0] == 4'h0, flags_ff[alu8f_pkg::FLAG_C]};
         end
         alu8f_pkg::OP_BIT: begin
            byte_r   = b;
            flags_in = {(b & bit_mask) == 8'd0, 1'b0, 1'b1, flags_ff[alu8f_pkg::FLAG_C]};
         end
         alu8f_pkg::OP_RES: begin
            byte_r = b & ~bit_mask;
         end
         alu8f_pkg::OP_SET: begin
            byte_r = b | bit_mask;
         end
         default: begin
            byte_r = 8'd0;
         end
      endcase
      result_in = {8'd0, byte_r};
      // The 16-bit add is the only operation with a full-width result.
      if (in_data_ff.op == alu8f_pkg::OP_ADD16) begin
         result_in = sum17[15:0];
         flags_in  = {flags_ff[alu8f_pkg::FLAG_Z], 1'b0, sum13[12], sum17[16]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (in_move) begin
            in_valid_ff <= 1'b0;
         end
         if (out_open) begin
            out_valid_ff <= in_valid_ff;
         end
         if (in_move) begin
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= '{op:             req_op,
                         first_operand:  req_first_operand,
                         second_operand: req_second_operand,
                         bit_index:      req_bit_index};
      end
      if (in_move) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result         = out_result_ff;
   assign rsp_zero_out       = flags_ff[alu8f_pkg::FLAG_Z];
   assign rsp_subtract_out   = flags_ff[alu8f_pkg::FLAG_N];
   assign rsp_half_carry_out = flags_ff[alu8f_pkg::FLAG_H];
   assign rsp_carry_out      = flags_ff[alu8f_pkg::FLAG_C];

endmodule

// File: rtl/alu8f_checker.sv
`include "eight_bit_alu_with_flags_assert.svh"

module alu8f_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input alu8f_pkg::op_type   req_op,
   input alu8f_pkg::word_type req_first_operand,
   input alu8f_pkg::word_type req_second_operand,
   input alu8f_pkg::idx_type  req_bit_index,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input alu8f_pkg::word_type rsp_result,
   input logic                rsp_zero_out,
   input logic                rsp_subtract_out,
   input logic                rsp_half_carry_out,
   input logic                rsp_carry_out
);

   logic req_beat;
   logic rsp_view;

   assign req_beat = req_valid && !req_stall;
   // Gathers the payload so that every port is seen by the checker.
   assign rsp_view = ^{req_op, req_first_operand, req_second_operand, req_bit_index,
                       rsp_result, rsp_zero_out, rsp_subtract_out,
                       rsp_half_carry_out, rsp_carry_out} || 1'b1;

   `ALU8F_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "result valid after reset")

   `ALU8F_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "stalled result dropped")

   // Only a full, stalled result register may hold back the request side.
   `ALU8F_ASSERT(a_stall_cause, req_stall |-> rsp_valid && rsp_stall && rsp_view,
      "request stalled without a stalled result")

   // A request beat is always followed by a valid result on the result side, its own or a stalled older one.
   `ALU8F_ASSERT(a_beat_reaches_out, req_beat |=> ##1 rsp_valid, "request beat lost")

endmodule

bind eight_bit_alu_with_flags alu8f_checker u_alu8f_checker (.*);
